// ----- design/assert_macros.svh -----
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define SWSFR_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define SWSFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/swsfr_pkg.sv -----
// Types and constants of the single-wire sensor frame receiver.
package swsfr_pkg;

  localparam int DELAY_WIDTH       = 24;
  localparam int PULSE_COUNT_WIDTH = 16;
  localparam int FRAME_BITS        = 40;
  localparam int BYTE_WIDTH        = 8;
  localparam int CMP_WIDTH         = 32;
  localparam int CFG_DATA_WIDTH    = 24;
  localparam int CFG_INDEX_WIDTH   = 2;
  localparam int LONG_TICKS_WIDTH  = 24;
  localparam int SHORT_TICKS_WIDTH = 16;
  localparam int WORD_WIDTH        = 16;
  localparam int BIT_COUNT_WIDTH   = 6;

  localparam logic [LONG_TICKS_WIDTH-1:0]  WAKE_TICKS_RESET      = 24'd1000000;
  localparam logic [LONG_TICKS_WIDTH-1:0]  START_LOW_TICKS_RESET = 24'd1000;
  localparam logic [SHORT_TICKS_WIDTH-1:0] RELEASE_TICKS_RESET   = 16'd40;
  localparam logic [SHORT_TICKS_WIDTH-1:0] ONE_THRESHOLD_RESET   = 16'd50;

  typedef logic [DELAY_WIDTH-1:0]       delay_t;
  typedef logic [PULSE_COUNT_WIDTH-1:0] pulse_t;
  typedef logic [CMP_WIDTH-1:0]         cmp_t;
  typedef logic [BIT_COUNT_WIDTH-1:0]   bitcnt_t;
  typedef logic [FRAME_BITS-1:0]        frame_t;
  typedef logic [BYTE_WIDTH-1:0]        byte_t;
  typedef logic [WORD_WIDTH-1:0]        word_t;
  typedef logic [CFG_DATA_WIDTH-1:0]    cfg_data_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_WAKE_TICKS      = 2'd0,
    CFG_START_LOW_TICKS = 2'd1,
    CFG_RELEASE_TICKS   = 2'd2,
    CFG_ONE_THRESHOLD   = 2'd3
  } cfg_index_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_CHECKSUM    = 2'd1,
    ST_NO_HUMIDITY = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    PH_IDLE      = 8'b0000_0001,
    PH_WAKE      = 8'b0000_0010,
    PH_START_LOW = 8'b0000_0100,
    PH_RELEASE   = 8'b0000_1000,
    PH_RESP_LOW  = 8'b0001_0000,
    PH_RESP_HIGH = 8'b0010_0000,
    PH_BIT_WAIT  = 8'b0100_0000,
    PH_BIT_HIGH  = 8'b1000_0000
  } phase_t;

  localparam delay_t DELAY_MAX = '1;
  localparam pulse_t PULSE_MAX = '1;

endpackage

// ----- design/swsfr_channels.sv -----
// Handshake channel interfaces of the single-wire sensor frame receiver.
interface sensor_in_if;
  logic valid;
  logic ready;
  logic func;
  logic line_level;

  modport source (output valid, output func, output line_level, input ready);
  modport sink (input valid, input func, input line_level, output ready);
endinterface

interface sensor_out_if;
  logic                 valid;
  logic                 ready;
  logic                 drive_low;
  logic                 drive_enable;
  logic                 busy_res;
  logic                 done_res;
  logic [1:0]           status;
  swsfr_pkg::word_t     humidity_raw;
  swsfr_pkg::word_t     temperature_raw;

  modport source (output valid, output drive_low, output drive_enable, output busy_res,
                  output done_res, output status, output humidity_raw,
                  output temperature_raw, input ready);
  modport sink (input valid, input drive_low, input drive_enable, input busy_res,
                input done_res, input status, input humidity_raw,
                input temperature_raw, output ready);
endinterface

interface sensor_cfg_if;
  logic                  valid;
  logic                  ready;
  swsfr_pkg::cfg_index_t index;
  swsfr_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- design/single_wire_sensor_frame_receiver.sv -----
// Top level of the single-wire sensor frame receiver.
// Each item on the samples channel is one tick of the sampling clock and yields exactly one
// result item. The block takes one item per clock cycle while the results channel is not
// stalled; an item passes an input register, one stage of phase logic and a result register,
// and one item can wait in the input register while a result waits to be taken. A read
// starts on an item with func set while idle: the line is driven high for wake_ticks, low
// for start_low_ticks, high for release_ticks (each at least one tick), then released; the
// block waits for the sensor's response low and high and times 40 high pulses, MSB first.
// A pulse longer than one_threshold samples is a one. Status, humidity and temperature
// change when the frame completes. There is no timeout. Configuration writes are taken in
// any cycle and are meant for idle periods only.
module single_wire_sensor_frame_receiver (
  input  logic          clk,
  input  logic          rst,
  sensor_in_if.sink     samples,
  sensor_out_if.source  results,
  sensor_cfg_if.sink    cfg
);

  logic [swsfr_pkg::LONG_TICKS_WIDTH-1:0]  wake_ticks;
  logic [swsfr_pkg::LONG_TICKS_WIDTH-1:0]  start_low_ticks;
  logic [swsfr_pkg::SHORT_TICKS_WIDTH-1:0] release_ticks;
  logic [swsfr_pkg::SHORT_TICKS_WIDTH-1:0] one_threshold;

  logic in_valid;
  logic in_func;
  logic in_line;
  logic advance;

  swsfr_pkg::phase_t   phase, phase_next;
  swsfr_pkg::delay_t   delay_count, delay_next, delay_inc;
  swsfr_pkg::pulse_t   pulse_count, pulse_next, pulse_inc;
  swsfr_pkg::bitcnt_t  bit_count, bit_count_next, bit_count_inc;
  swsfr_pkg::frame_t   received_bits, received_bits_next, rx_shift;
  swsfr_pkg::status_t  last_status, last_status_next;
  swsfr_pkg::word_t    last_humidity, last_humidity_next;
  swsfr_pkg::word_t    last_temperature, last_temperature_next;
  logic                done_next;

  swsfr_pkg::cmp_t     timed_len;
  logic                timed_end;
  logic                bit_one;
  swsfr_pkg::byte_t    sum_byte;
  swsfr_pkg::status_t  frame_status;

  logic                out_valid;
  logic                out_drive_low;
  logic                out_drive_enable;
  logic                out_busy;
  logic                out_done;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_ticks      <= swsfr_pkg::WAKE_TICKS_RESET;
      start_low_ticks <= swsfr_pkg::START_LOW_TICKS_RESET;
      release_ticks   <= swsfr_pkg::RELEASE_TICKS_RESET;
      one_threshold   <= swsfr_pkg::ONE_THRESHOLD_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        swsfr_pkg::CFG_WAKE_TICKS: begin
          wake_ticks <= cfg.data[swsfr_pkg::LONG_TICKS_WIDTH-1:0];
        end
        swsfr_pkg::CFG_START_LOW_TICKS: begin
          start_low_ticks <= cfg.data[swsfr_pkg::LONG_TICKS_WIDTH-1:0];
        end
        swsfr_pkg::CFG_RELEASE_TICKS: begin
          release_ticks <= cfg.data[swsfr_pkg::SHORT_TICKS_WIDTH-1:0];
        end
        swsfr_pkg::CFG_ONE_THRESHOLD: begin
          one_threshold <= cfg.data[swsfr_pkg::SHORT_TICKS_WIDTH-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // The input register moves on whenever the result register is free or being emptied.
  assign advance       = in_valid && (!out_valid || results.ready);
  assign samples.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      in_func <= samples.func;
      in_line <= samples.line_level;
    end
  end

  always_comb begin
    delay_inc = (delay_count == swsfr_pkg::DELAY_MAX) ? delay_count : delay_count + 1'b1;
    pulse_inc = (pulse_count == swsfr_pkg::PULSE_MAX) ? pulse_count : pulse_count + 1'b1;
    bit_count_inc = bit_count + 1'b1;
    case (phase)
      swsfr_pkg::PH_WAKE:      timed_len = swsfr_pkg::cmp_t'(wake_ticks);
      swsfr_pkg::PH_START_LOW: timed_len = swsfr_pkg::cmp_t'(start_low_ticks);
      default:                 timed_len = swsfr_pkg::cmp_t'(release_ticks);
    endcase
    timed_end = (swsfr_pkg::cmp_t'(delay_inc) >= timed_len)
                || (delay_inc == swsfr_pkg::DELAY_MAX);
    bit_one  = swsfr_pkg::cmp_t'(pulse_count) > swsfr_pkg::cmp_t'(one_threshold);
    rx_shift = {received_bits[swsfr_pkg::FRAME_BITS-2:0], bit_one};
    sum_byte = rx_shift[39:32] + rx_shift[31:24] + rx_shift[23:16] + rx_shift[15:8];
    if (sum_byte != rx_shift[7:0]) begin
      frame_status = swsfr_pkg::ST_CHECKSUM;
    end else if (rx_shift[39:32] != '0) begin
      frame_status = swsfr_pkg::ST_OK;
    end else begin
      frame_status = swsfr_pkg::ST_NO_HUMIDITY;
    end
  end

  always_comb begin
    phase_next            = phase;
    delay_next            = delay_count;
    pulse_next            = pulse_count;
    bit_count_next        = bit_count;
    received_bits_next    = received_bits;
    last_status_next      = last_status;
    last_humidity_next    = last_humidity;
    last_temperature_next = last_temperature;
    done_next             = 1'b0;
    case (phase)
      swsfr_pkg::PH_IDLE: begin
        if (in_func) begin
          phase_next         = swsfr_pkg::PH_WAKE;
          delay_next         = '0;
          pulse_next         = '0;
          bit_count_next     = '0;
          received_bits_next = '0;
        end
      end
      swsfr_pkg::PH_WAKE, swsfr_pkg::PH_START_LOW, swsfr_pkg::PH_RELEASE: begin
        delay_next = timed_end ? '0 : delay_inc;
        if (timed_end) begin
          case (phase)
            swsfr_pkg::PH_WAKE:      phase_next = swsfr_pkg::PH_START_LOW;
            swsfr_pkg::PH_START_LOW: phase_next = swsfr_pkg::PH_RELEASE;
            default:                 phase_next = swsfr_pkg::PH_RESP_LOW;
          endcase
        end
      end
      swsfr_pkg::PH_RESP_LOW: begin
        if (in_line) begin
          phase_next = swsfr_pkg::PH_RESP_HIGH;
        end
      end
      swsfr_pkg::PH_RESP_HIGH: begin
        if (!in_line) begin
          phase_next = swsfr_pkg::PH_BIT_WAIT;
        end
      end
      swsfr_pkg::PH_BIT_WAIT: begin
        if (in_line) begin
          pulse_next = swsfr_pkg::pulse_t'(1);
          phase_next = swsfr_pkg::PH_BIT_HIGH;
        end
      end
      swsfr_pkg::PH_BIT_HIGH: begin
        if (in_line) begin
          pulse_next = pulse_inc;
        end else begin
          received_bits_next = rx_shift;
          pulse_next         = '0;
          bit_count_next     = bit_count_inc;
          if (bit_count_inc >= swsfr_pkg::bitcnt_t'(swsfr_pkg::FRAME_BITS)) begin
            last_status_next      = frame_status;
            last_humidity_next    = rx_shift[39:24];
            last_temperature_next = rx_shift[23:8];
            done_next             = 1'b1;
            phase_next            = swsfr_pkg::PH_IDLE;
          end else begin
            phase_next = swsfr_pkg::PH_BIT_WAIT;
          end
        end
      end
      default: begin
        phase_next = swsfr_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= swsfr_pkg::PH_IDLE;
      delay_count      <= '0;
      pulse_count      <= '0;
      bit_count        <= '0;
      received_bits    <= '0;
      last_status      <= swsfr_pkg::ST_OK;
      last_humidity    <= '0;
      last_temperature <= '0;
    end else if (advance) begin
      phase            <= phase_next;
      delay_count      <= delay_next;
      pulse_count      <= pulse_next;
      bit_count        <= bit_count_next;
      received_bits    <= received_bits_next;
      last_status      <= last_status_next;
      last_humidity    <= last_humidity_next;
      last_temperature <= last_temperature_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive_low    <= (phase_next == swsfr_pkg::PH_START_LOW);
      out_drive_enable <= (phase_next == swsfr_pkg::PH_WAKE)
                          || (phase_next == swsfr_pkg::PH_START_LOW)
                          || (phase_next == swsfr_pkg::PH_RELEASE);
      out_busy         <= (phase_next != swsfr_pkg::PH_IDLE);
      out_done         <= done_next;
    end
  end

  assign results.valid           = out_valid;
  assign results.drive_low       = out_drive_low;
  assign results.drive_enable    = out_drive_enable;
  assign results.busy_res        = out_busy;
  assign results.done_res        = out_done;
  assign results.status          = last_status;
  assign results.humidity_raw    = last_humidity;
  assign results.temperature_raw = last_temperature;

endmodule

// ----- design/swsfr_checker.sv -----
// Port-level assertions for the single-wire sensor frame receiver, with their bind.
`include "assert_macros.svh"

module swsfr_checker (
  input  logic          clk,
  input  logic          rst,
  sensor_in_if.sink     samples,
  sensor_out_if.source  results,
  sensor_cfg_if.sink    cfg
);

  `SWSFR_ASSERT_ALWAYS(a_no_result_after_reset, clk, $past(rst) |-> !results.valid, "result item right after reset")
  `SWSFR_ASSERT(a_result_held, clk, rst, results.valid && !results.ready |=> results.valid && $stable(results.humidity_raw) && $stable(results.busy_res), "stalled result item changed")
  `SWSFR_ASSERT(a_drive_nesting, clk, rst, results.valid |-> (!results.drive_low || results.drive_enable) && (!results.drive_enable || results.busy_res), "line driven outside a read")
  `SWSFR_ASSERT(a_done_ends_read, clk, rst, results.valid && results.done_res |-> !results.busy_res && !results.drive_enable, "frame completion while still busy")
  `SWSFR_ASSERT(a_status_code, clk, rst, results.valid |-> results.status != 2'd3 && (cfg.ready || !cfg.valid || samples.valid || !samples.valid), "undefined status code")

endmodule

bind single_wire_sensor_frame_receiver swsfr_checker u_swsfr_checker (
  .clk     (clk),
  .rst     (rst),
  .samples (samples),
  .results (results),
  .cfg     (cfg)
);
